@@ rtl/pftbp_pkg.sv @@
// Shared types, constants and codes of the per-flow token bucket policer.
`default_nettype none

package pftbp_pkg;

    localparam int SLOT_W        = 12;
    localparam int TIME_W        = 64;
    localparam int TOK_W         = 32;
    localparam int CFG_IDX_W     = 8;
    localparam int SLOTS_DEFAULT = 4096;

    localparam int NS_W = 30;
    localparam logic [NS_W-1:0]  NS_PER_SEC   = 30'd1000000000;
    localparam logic [TOK_W-1:0] NS_PER_SEC_1 = 32'd1000000000;
    localparam logic [TOK_W-1:0] NS_PER_SEC_2 = 32'd2000000000;
    localparam logic [TOK_W-1:0] NS_PER_SEC_3 = 32'd3000000000;

    localparam int DIV_STEPS = 16;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_RATE  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_BURST = 8'd1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_INDEX,
        ST_ADDR,
        ST_READ,
        ST_ELAPSED,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_SUM,
        ST_CMP,
        ST_DIV,
        ST_WRITE
    } t_state;

    typedef struct packed {
        logic              valid;
        logic [TOK_W-1:0]  tokens;
        logic [TIME_W-1:0] last_time;
    } t_entry;

    typedef struct packed {
        logic clear;
        logic load;
        logic emit_pass;
        logic calc_idx;
        logic calc_addr;
        logic calc_elapsed;
        logic wr_new;
        logic mul_lo;
        logic mul_hi;
        logic sum;
        logic cmp;
        logic div_step;
        logic wr_update;
    } t_dp_cmd;

    typedef struct packed {
        logic active;
        logic slot_valid;
        logic sat;
        logic clr_last;
    } t_dp_sts;

endpackage

`default_nettype wire

@@ rtl/per_flow_token_bucket_policer.sv @@
// Top level of the per-flow token bucket policer.
//
//  channel   | handshake                | payload
//  ----------+--------------------------+-------------------------------------------
//  item in   | i_start, o_busy          | i_source_slot, i_now_ns, i_policy_*
//  result    | o_done (one-cycle strobe)| o_verdict, o_entry_created
//  config    | i_cfg_valid, o_cfg_ready | i_cfg_index, i_cfg_data
//
// An item is taken when i_start is high and o_busy low; one result follows per item.
// No new item is taken before that result. With no active policy the item passes;
// an empty slot is filled; a full refill skips the divide, else 16 radix-4 steps
// divide by one second in ns. After reset o_busy is high while the slot table clears.
// Results are strobed for a single cycle; the receiver cannot stall them.
`default_nettype none

module per_flow_token_bucket_policer #(
    parameter int SLOTS = pftbp_pkg::SLOTS_DEFAULT
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_start,
    output logic                                  o_busy,
    input  wire logic [pftbp_pkg::SLOT_W-1:0]     i_source_slot,
    input  wire logic [pftbp_pkg::TIME_W-1:0]     i_now_ns,
    input  wire logic                             i_policy_present,
    input  wire logic [pftbp_pkg::TOK_W-1:0]      i_policy_rate,
    input  wire logic [pftbp_pkg::TOK_W-1:0]      i_policy_burst,
    output logic                                  o_done,
    output logic                                  o_verdict,
    output logic                                  o_entry_created,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [pftbp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [pftbp_pkg::TOK_W-1:0]      i_cfg_data
);
    import pftbp_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    assign o_cfg_ready = 1'b1;

    pftbp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (o_busy)
    );

    pftbp_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_cfg_we         (i_cfg_valid && o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_source_slot    (i_source_slot),
        .i_now_ns         (i_now_ns),
        .i_policy_present (i_policy_present),
        .i_policy_rate    (i_policy_rate),
        .i_policy_burst   (i_policy_burst),
        .o_done           (o_done),
        .o_verdict        (o_verdict),
        .o_entry_created  (o_entry_created)
    );

endmodule

`default_nettype wire

@@ rtl/pftbp_ctrl.sv @@
// Sequencing state machine of the policer: clearing pass, item steps, divide loop.
`default_nettype none

module pftbp_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire pftbp_pkg::t_dp_sts i_sts,
    output pftbp_pkg::t_dp_cmd      o_cmd,
    output logic                    o_busy
);
    import pftbp_pkg::*;

    t_state              r_state, n_state;
    logic [STEP_W-1:0]   r_step, n_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR:   if (i_sts.clr_last) n_state = ST_IDLE;
            ST_IDLE:    if (i_start && i_sts.active) n_state = ST_INDEX;
            ST_INDEX:   n_state = ST_ADDR;
            ST_ADDR:    n_state = ST_READ;
            ST_READ:    n_state = ST_ELAPSED;
            ST_ELAPSED: n_state = i_sts.slot_valid ? ST_MUL_LO : ST_IDLE;
            ST_MUL_LO:  n_state = ST_MUL_HI;
            ST_MUL_HI:  n_state = ST_SUM;
            ST_SUM:     n_state = ST_CMP;
            ST_CMP:     n_state = i_sts.sat ? ST_WRITE : ST_DIV;
            ST_DIV:     if (r_step == STEP_W'(DIV_STEPS - 1)) n_state = ST_WRITE;
            ST_WRITE:   n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_step = r_step;
        case (r_state)
            ST_CMP:  n_step = '0;
            ST_DIV:  n_step = r_step + 1'b1;
            default: n_step = r_step;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            ST_CLEAR:   o_cmd.clear = 1'b1;
            ST_IDLE: begin
                o_cmd.load      = i_start;
                o_cmd.emit_pass = i_start && !i_sts.active;
            end
            ST_INDEX:   o_cmd.calc_idx = 1'b1;
            ST_ADDR:    o_cmd.calc_addr = 1'b1;
            ST_READ:    o_cmd = '0;
            ST_ELAPSED: begin
                o_cmd.calc_elapsed = 1'b1;
                o_cmd.wr_new       = !i_sts.slot_valid;
            end
            ST_MUL_LO:  o_cmd.mul_lo = 1'b1;
            ST_MUL_HI:  o_cmd.mul_hi = 1'b1;
            ST_SUM:     o_cmd.sum = 1'b1;
            ST_CMP:     o_cmd.cmp = 1'b1;
            ST_DIV:     o_cmd.div_step = 1'b1;
            ST_WRITE:   o_cmd.wr_update = 1'b1;
            default:    o_cmd = '0;
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule

`default_nettype wire

@@ rtl/pftbp_dp.sv @@
// Policer datapath: config registers, slot table, refill arithmetic, result registers.
`default_nettype none

module pftbp_dp #(
    parameter int SLOTS = pftbp_pkg::SLOTS_DEFAULT
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire pftbp_pkg::t_dp_cmd               i_cmd,
    output pftbp_pkg::t_dp_sts                    o_sts,
    input  wire logic                             i_cfg_we,
    input  wire logic [pftbp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [pftbp_pkg::TOK_W-1:0]      i_cfg_data,
    input  wire logic [pftbp_pkg::SLOT_W-1:0]     i_source_slot,
    input  wire logic [pftbp_pkg::TIME_W-1:0]     i_now_ns,
    input  wire logic                             i_policy_present,
    input  wire logic [pftbp_pkg::TOK_W-1:0]      i_policy_rate,
    input  wire logic [pftbp_pkg::TOK_W-1:0]      i_policy_burst,
    output logic                                  o_done,
    output logic                                  o_verdict,
    output logic                                  o_entry_created
);
    import pftbp_pkg::*;

    localparam int IDX_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int RED_SHIFT = SLOT_W + IDX_W;
    localparam int MULT_W    = SLOT_W + 2;
    localparam longint RED_MULT_L = ((64'd1 << RED_SHIFT) + SLOTS - 1) / SLOTS;
    localparam logic [MULT_W-1:0] RED_MULT = MULT_W'(RED_MULT_L);
    localparam int SPAN_W    = SLOT_W + IDX_W + 1;
    localparam logic [SPAN_W-1:0] SLOTS_V = SPAN_W'(SLOTS);
    localparam int PROD_W    = 3 * TOK_W;
    localparam int NEED_W    = TOK_W + NS_W;

    // config
    logic [TOK_W-1:0] r_def_rate;
    logic [TOK_W-1:0] r_def_burst;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_def_rate  <= '0;
            r_def_burst <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DEFAULT_RATE:  r_def_rate  <= i_cfg_data;
                CFG_DEFAULT_BURST: r_def_burst <= i_cfg_data;
                default:           r_def_burst <= r_def_burst;
            endcase
        end
    end

    // policy selection
    logic pol_on, def_on;
    assign pol_on = i_policy_present && (|i_policy_rate) && (|i_policy_burst);
    assign def_on = (|r_def_rate) && (|r_def_burst);

    logic [SLOT_W-1:0]  r_slot;
    logic [TIME_W-1:0]  r_now;
    logic [TOK_W-1:0]   r_rate;
    logic [TOK_W-1:0]   r_burst;
    logic [SLOT_W-1:0]  r_quot;
    logic [IDX_W-1:0]   r_addr;
    t_entry             r_rd;
    t_entry             r_mem [SLOTS];
    logic [TIME_W-1:0]  r_elapsed;
    logic [TOK_W-1:0]   r_tok;
    logic               r_full;
    logic [TOK_W-1:0]   r_need;
    logic [NEED_W-1:0]  r_need_d;
    logic [2*TOK_W-1:0] r_pp_lo;
    logic [2*TOK_W-1:0] r_pp_hi;
    logic [PROD_W-1:0]  r_prod;
    logic               r_sat;
    logic [NS_W-1:0]    r_rem;
    logic [TOK_W-1:0]   r_dvd;
    logic [TOK_W-1:0]   r_quo;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_slot  <= i_source_slot;
            r_now   <= i_now_ns;
            r_rate  <= pol_on ? i_policy_rate  : r_def_rate;
            r_burst <= pol_on ? i_policy_burst : r_def_burst;
        end
    end

    // slot modulo table depth by reciprocal multiply (exact for 12-bit slots)
    logic [SLOT_W+MULT_W-1:0] quot_prod;
    logic [SPAN_W-1:0]        span;
    logic [SPAN_W-1:0]        rem_full;

    assign quot_prod = (SLOT_W+MULT_W)'(r_slot) * (SLOT_W+MULT_W)'(RED_MULT);
    assign span      = SPAN_W'(r_quot) * SLOTS_V;
    assign rem_full  = SPAN_W'(r_slot) - span;

    always_ff @(posedge i_clk) begin
        if (i_cmd.calc_idx) r_quot <= SLOT_W'(quot_prod >> RED_SHIFT);
    end

    // address doubles as the clearing sweep pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= '0;
        end else if (i_cmd.clear) begin
            r_addr <= r_addr + 1'b1;
        end else if (i_cmd.calc_addr) begin
            r_addr <= rem_full[IDX_W-1:0];
        end
    end

    // refill arithmetic
    logic [2*TOK_W-1:0] pp_lo, pp_hi;
    logic [NEED_W-1:0]  need_d;
    logic               sat_c;

    assign pp_lo  = r_elapsed[TOK_W-1:0] * r_rate;
    assign pp_hi  = r_elapsed[TIME_W-1:TOK_W] * r_rate;
    assign need_d = r_need * NS_PER_SEC;
    assign sat_c  = r_full || (r_prod >= PROD_W'(r_need_d));

    always_ff @(posedge i_clk) begin
        if (i_cmd.calc_elapsed) begin
            r_elapsed <= r_now - r_rd.last_time;
            r_tok     <= r_rd.tokens;
            r_full    <= (r_rd.tokens >= r_burst);
            r_need    <= r_burst - r_rd.tokens;
        end
        if (i_cmd.mul_lo) begin
            r_pp_lo  <= pp_lo;
            r_need_d <= need_d;
        end
        if (i_cmd.mul_hi) r_pp_hi <= pp_hi;
        if (i_cmd.sum) r_prod <= PROD_W'(r_pp_lo) + {r_pp_hi, {TOK_W{1'b0}}};
    end

    // radix-4 divide by one second in ns
    logic [TOK_W-1:0] rem4;
    logic [TOK_W-1:0] rem_n;
    logic [1:0]       q_dig;

    assign rem4 = {r_rem, r_dvd[TOK_W-1 -: 2]};

    always_comb begin
        if (rem4 >= NS_PER_SEC_3) begin
            q_dig = 2'd3;
            rem_n = rem4 - NS_PER_SEC_3;
        end else if (rem4 >= NS_PER_SEC_2) begin
            q_dig = 2'd2;
            rem_n = rem4 - NS_PER_SEC_2;
        end else if (rem4 >= NS_PER_SEC_1) begin
            q_dig = 2'd1;
            rem_n = rem4 - NS_PER_SEC_1;
        end else begin
            q_dig = 2'd0;
            rem_n = rem4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cmp) begin
            r_sat <= sat_c;
            r_rem <= r_prod[TOK_W +: NS_W];
            r_dvd <= r_prod[TOK_W-1:0];
            r_quo <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= rem_n[NS_W-1:0];
            r_dvd <= {r_dvd[TOK_W-3:0], 2'b00};
            r_quo <= {r_quo[TOK_W-3:0], q_dig};
        end
    end

    // token update
    logic [TOK_W-1:0] tok_new;
    logic             tok_zero;
    logic [TOK_W-1:0] tok_store;

    assign tok_new   = r_sat ? r_burst : (r_tok + r_quo);
    assign tok_zero  = (tok_new == '0);
    assign tok_store = tok_zero ? '0 : (tok_new - 1'b1);

    // slot table
    logic   mem_we;
    t_entry wr_entry;

    always_comb begin
        mem_we   = i_cmd.clear || i_cmd.wr_new || i_cmd.wr_update;
        wr_entry = '0;
        if (i_cmd.wr_new) begin
            wr_entry.valid     = 1'b1;
            wr_entry.tokens    = r_burst;
            wr_entry.last_time = r_now;
        end else if (i_cmd.wr_update) begin
            wr_entry.valid     = 1'b1;
            wr_entry.tokens    = tok_store;
            wr_entry.last_time = r_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[r_addr] <= wr_entry;
        r_rd <= r_mem[r_addr];
    end

    // result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= i_cmd.emit_pass || i_cmd.wr_new || i_cmd.wr_update;
        end
        o_verdict       <= i_cmd.wr_update && tok_zero;
        o_entry_created <= i_cmd.wr_new;
    end

    assign o_sts.active     = pol_on || def_on;
    assign o_sts.slot_valid = r_rd.valid;
    assign o_sts.sat        = sat_c;
    assign o_sts.clr_last   = (r_addr == IDX_W'(SLOTS - 1));

endmodule

`default_nettype wire
